/* src/wss_pkg.sv */
package wss_pkg;

  localparam int BITS_PER_PIXEL = 24;
  localparam int CNT_W = $clog2(BITS_PER_PIXEL);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_PIXEL - 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [2:0] REG_ONE_HIGH = 3'd1;
  localparam logic [2:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [2:0] REG_BIT_PERIOD = 3'd3;
  localparam logic [2:0] REG_LATCH_LOW = 3'd4;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_LATCH = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic        bit_value;
    logic        is_latch;
    logic [7:0]  high_ticks;
    logic [15:0] low_ticks;
    logic        last_symbol;
  } symbol_out_t;

  typedef struct packed {
    logic [7:0]  brightness;
    logic [7:0]  one_high_ticks;
    logic [7:0]  zero_high_ticks;
    logic [8:0]  bit_period_ticks;
    logic [15:0] latch_low_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic                      op;
    logic [BITS_PER_PIXEL-1:0] word;
  } queue_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } queue_ctrl_t;

  // Exact division by 255 for any 16-bit product of two bytes.
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] sum;
    sum = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

/* src/ws281x_pixel_serializer.sv */
// Line-code encoder for WS2812-style LED strips.
// The input channel carries one transaction per pixel or latch request. A
// pixel has each colour scaled by brightness/255 and becomes 24 symbols in
// green, red, blue order, most significant bit first; a latch request becomes
// one low-only symbol. The output channel carries one symbol per transaction,
// with last_symbol set on the final symbol of each input transaction.
// Timing and brightness are set through the write port; the user must write
// them only while the block is idle, as the block itself does not enforce it.
// An accepted pixel passes through the multiply stage, then the queue, then
// the output register. The output side gives one symbol per cycle while the
// queue holds an entry and the receiver does not stall, so a pixel occupies
// the output for 24 symbols and a latch for one. A two-entry queue lets the
// front end take new transactions while the back end is busy.
// When the receiver stalls, the output transaction holds, the queue fills and
// then the multiply stage holds, after which the input is stalled. Reset empties
// the pipeline and queue and loads the default timing and brightness values.
module ws281x_pixel_serializer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wss_pkg::pixel_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wss_pkg::symbol_out_t out_data,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import wss_pkg::*;

  cfg_regs_t    cfg;
  queue_entry_t push_data;
  queue_entry_t head;
  queue_ctrl_t  qctrl;
  logic         push;
  logic         pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brightness <= 8'd255;
      cfg.one_high_ticks <= 8'd40;
      cfg.zero_high_ticks <= 8'd20;
      cfg.bit_period_ticks <= 9'd62;
      cfg.latch_low_ticks <= 16'd2500;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BRIGHTNESS: cfg.brightness <= cfg_data[7:0];
        REG_ONE_HIGH: cfg.one_high_ticks <= cfg_data[7:0];
        REG_ZERO_HIGH: cfg.zero_high_ticks <= cfg_data[7:0];
        REG_BIT_PERIOD: cfg.bit_period_ticks <= cfg_data[8:0];
        REG_LATCH_LOW: cfg.latch_low_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  wss_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .brightness (cfg.brightness),
    .queue_full (qctrl.full),
    .queue_push (push),
    .queue_data (push_data)
  );

  wss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .ctrl      (qctrl)
  );

  wss_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!qctrl.empty),
    .pop        (pop),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

/* src/wss_front.sv */
module wss_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  wss_pkg::pixel_in_t    in_data,
  input  logic [7:0]            brightness,
  input  logic                  queue_full,
  output logic                  queue_push,
  output wss_pkg::queue_entry_t queue_data
);
  import wss_pkg::*;

  logic        stage_valid;
  logic        stage_op;
  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;
  logic        accept;

  assign in_stall = stage_valid && queue_full;
  assign accept = in_valid && !in_stall;
  assign queue_push = stage_valid && !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (queue_push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_op <= in_data.op;
      prod_r <= {8'd0, in_data.red} * {8'd0, brightness};
      prod_g <= {8'd0, in_data.green} * {8'd0, brightness};
      prod_b <= {8'd0, in_data.blue} * {8'd0, brightness};
    end
  end

  always_comb begin
    queue_data.op = stage_op;
    queue_data.word = {div255(prod_g), div255(prod_r), div255(prod_b)};
  end

endmodule

/* src/wss_queue.sv */
module wss_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  wss_pkg::queue_entry_t push_data,
  input  logic                  pop,
  output wss_pkg::queue_entry_t head,
  output wss_pkg::queue_ctrl_t  ctrl
);
  import wss_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  queue_entry_t           entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [PTR_W:0]         count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign head = entries[rd_ptr];

  always_comb begin
    ctrl.push = push;
    ctrl.pop = pop;
    ctrl.full = (count == (PTR_W+1)'(QUEUE_DEPTH));
    ctrl.empty = (count == '0);
  end

endmodule

/* src/wss_back.sv */
module wss_back (
  input  logic                  clk,
  input  logic                  rst,
  input  wss_pkg::queue_entry_t head,
  input  logic                  head_valid,
  output logic                  pop,
  input  wss_pkg::cfg_regs_t    cfg,
  output logic                  out_valid,
  input  logic                  out_stall,
  output wss_pkg::symbol_out_t  out_data
);
  import wss_pkg::*;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] bit_idx;
  logic             load;
  logic             last;
  logic             cur_bit;
  logic [7:0]       high;
  symbol_out_t      sym;

  assign load = head_valid && (!out_valid || !out_stall);
  assign last = (head.op == OP_LATCH) || (cnt == LAST_BIT);
  assign pop = load && last;
  assign bit_idx = LAST_BIT - cnt;
  assign cur_bit = head.word[bit_idx];
  assign high = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;

  always_comb begin
    if (head.op == OP_LATCH) begin
      sym.bit_value = 1'b0;
      sym.is_latch = 1'b1;
      sym.high_ticks = '0;
      sym.low_ticks = cfg.latch_low_ticks;
      sym.last_symbol = 1'b1;
    end else begin
      sym.bit_value = cur_bit;
      sym.is_latch = 1'b0;
      sym.high_ticks = high;
      sym.low_ticks = (cfg.bit_period_ticks > {1'b0, high}) ?
                      16'(cfg.bit_period_ticks - {1'b0, high}) : '0;
      sym.last_symbol = last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cnt <= last ? '0 : cnt + CNT_W'(1);
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= sym;
    end
  end

endmodule

/* src/wss_checker.sv */
module wss_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input wss_pkg::symbol_out_t out_data
);
  import wss_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_latch_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_latch |->
      out_data.last_symbol && !out_data.bit_value && out_data.high_ticks == 8'd0)
    else $error("malformed latch symbol");

  a_after_latch: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last_symbol |=>
      out_valid && !out_data.is_latch)
    else $error("pixel run broken before its last symbol");

endmodule

bind ws281x_pixel_serializer wss_checker u_wss_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
